/* design/bchs_pkg.sv */
// Shared types, codes and constants for the block-to-CHS command issuer.
// Holds the divider token, the configuration record and the register codes.
// No dependencies.
package bchs_pkg;

	// Width of the block address that takes part in the conversion.
	localparam int unsigned AW = 32;

	localparam logic [7:0] DH_MASTER = 8'hA0;
	localparam logic [7:0] DH_SLAVE  = 8'hB0;
	localparam logic [7:0] CMD_READ  = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;

	// Cells per divider section, and the section starts in the row.
	localparam int unsigned SEC_LEN    = AW;
	localparam int unsigned N_CELLS    = 3 * AW;
	localparam int unsigned SEC1_START = AW;
	localparam int unsigned SEC2_START = 2 * AW;

	typedef enum logic [2:0] {
		SEL_DRVHEAD = 3'd0,
		SEL_COUNT   = 3'd1,
		SEL_SECTOR  = 3'd2,
		SEL_CYL_LO  = 3'd3,
		SEL_CYL_HI  = 3'd4,
		SEL_COMMAND = 3'd5
	} sel_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_TYPE = 2'd1,
		ERR_BUF  = 2'd2,
		ERR_CYL  = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		CFG_DRIVE  = 3'd0,
		CFG_TYPE   = 3'd1,
		CFG_CYLS   = 3'd2,
		CFG_SPT    = 3'd3,
		CFG_SPC    = 3'd4,
		CFG_BLOCK  = 3'd5
	} cfg_idx_t;

	localparam logic [2:0] TYPE_CHS_ATA = 3'd1;
	localparam logic [2:0] TYPE_SATA    = 3'd5;

	typedef struct packed {
		logic        drive_select;
		logic [2:0]  device_type;
		logic [15:0] cylinders_total;
		logic [7:0]  sectors_per_track;
		logic [15:0] sectors_per_cylinder;
		logic [15:0] block_bytes;
	} cfg_t;

	// One request as it travels down the divider row.
	typedef struct packed {
		logic [AW-1:0] a;      // block address
		logic [AW-1:0] n;      // dividend bits still to shift in
		logic [AW-1:0] r;      // partial remainder
		logic [AW-1:0] q;      // quotient bits so far
		logic [AW-1:0] cyl;    // cylinder, once known
		logic [7:0]    sector;
		logic          func;
		err_t          err;
	} tok_t;

	// Start of the cylinder division: base = addr - addr mod spt.
	function automatic tok_t sec1_init(input tok_t t);
		tok_t o;
		o        = t;
		o.sector = t.r[7:0] + 8'd1;
		o.n      = t.a - t.r;
		o.r      = '0;
		o.q      = '0;
		return o;
	endfunction

	// Start of the head division: dividend is base mod spc.
	function automatic tok_t sec2_init(input tok_t t);
		tok_t o;
		o     = t;
		o.cyl = t.q;
		o.n   = t.r;
		o.r   = '0;
		o.q   = '0;
		return o;
	endfunction

endpackage

/* design/bchs_cell.sv */
// One restoring-division cell of the divider row: one quotient bit per cell.
// Depends on bchs_pkg for the token type.
module bchs_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  bchs_pkg::tok_t   tok_in,
	input  logic [15:0]      divisor,
	output logic             valid_out,
	output bchs_pkg::tok_t   tok_out
);
	logic [bchs_pkg::AW:0]   trial;
	logic [bchs_pkg::AW:0]   dext;
	logic [bchs_pkg::AW:0]   diff;
	logic                    ge;
	bchs_pkg::tok_t          step;
	logic                    valid_q;
	bchs_pkg::tok_t          tok_q;

	always_comb begin
		trial = {tok_in.r, tok_in.n[bchs_pkg::AW-1]};
		dext  = (bchs_pkg::AW+1)'(divisor);
		diff  = trial - dext;
		ge    = trial >= dext;
		step   = tok_in;
		step.r = ge ? diff[bchs_pkg::AW-1:0] : trial[bchs_pkg::AW-1:0];
		step.n = {tok_in.n[bchs_pkg::AW-2:0], 1'b0};
		step.q = {tok_in.q[bchs_pkg::AW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= step;
		end
	end

	assign valid_out = valid_q;
	assign tok_out   = tok_q;
endmodule

/* design/bchs_emit.sv */
// Result sequencer: takes a finished request off the divider row and plays
// out the task-file writes or one flagged result. Depends on bchs_pkg.
module bchs_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  bchs_pkg::cfg_t   cfg,
	input  logic             load,
	input  bchs_pkg::tok_t   tok,
	output logic             load_ok,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       reg_select,
	output logic [7:0]       reg_value,
	output logic [1:0]       error_code,
	output logic             last
);
	logic                busy_q;
	bchs_pkg::sel_t      idx_q;
	bchs_pkg::err_t      err_q;
	logic [7:0]          dh_q;
	logic [7:0]          sec_q;
	logic [15:0]         cyl_q;
	logic                func_q;
	bchs_pkg::err_t      err_new;
	logic                done;

	always_comb begin
		if (tok.err != bchs_pkg::ERR_OK) begin
			err_new = tok.err;
		end else if (tok.cyl >= bchs_pkg::AW'(cfg.cylinders_total)) begin
			err_new = bchs_pkg::ERR_CYL;
		end else begin
			err_new = bchs_pkg::ERR_OK;
		end
	end

	always_comb begin
		last = (err_q != bchs_pkg::ERR_OK) || (idx_q == bchs_pkg::SEL_COMMAND);
		reg_select = 3'(bchs_pkg::SEL_DRVHEAD);
		reg_value  = 8'd0;
		if (err_q == bchs_pkg::ERR_OK) begin
			reg_select = idx_q;
			unique case (idx_q)
				bchs_pkg::SEL_DRVHEAD: reg_value = dh_q;
				bchs_pkg::SEL_COUNT:   reg_value = 8'd1;
				bchs_pkg::SEL_SECTOR:  reg_value = sec_q;
				bchs_pkg::SEL_CYL_LO:  reg_value = cyl_q[7:0];
				bchs_pkg::SEL_CYL_HI:  reg_value = cyl_q[15:8];
				bchs_pkg::SEL_COMMAND: reg_value = func_q ? bchs_pkg::CMD_WRITE
				                                          : bchs_pkg::CMD_READ;
				default:               reg_value = 8'd0;
			endcase
		end
	end

	assign out_valid  = busy_q;
	assign error_code = err_q;
	assign done       = busy_q && !out_stall && last;
	assign load_ok    = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= bchs_pkg::SEL_DRVHEAD;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= bchs_pkg::SEL_DRVHEAD;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !out_stall) begin
			idx_q <= bchs_pkg::sel_t'(idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_q  <= err_new;
			dh_q   <= (cfg.drive_select ? bchs_pkg::DH_SLAVE : bchs_pkg::DH_MASTER)
			          | tok.q[7:0];
			sec_q  <= tok.sector;
			cyl_q  <= tok.cyl[15:0];
			func_q <= tok.func;
		end
	end
endmodule

/* design/block_to_chs_command_issuer_core.sv */
// Top level of the block-to-CHS command issuer: config registers, divider row
// and result sequencer. Depends on bchs_pkg, bchs_cell and bchs_emit.
//
// Each request (block number, read/write, buffer size) walks a row of 96
// restoring-division cells, one quotient bit per cell: the first 32 take
// the block number modulo sectors per track, the next 32 divide the
// track-aligned base by sectors per cylinder, the last 32 divide that
// remainder by sectors per track to give the head. A request enters the
// row every cycle the row moves and passes through the 96 cell registers
// into the sequencer, which plays out six task-file writes (drive/head,
// count, sector, cylinder low, cylinder high, command) at one per cycle
// while out_stall is low, or one flagged result if the device type, buffer
// size or cylinder range check fails; the sequencer's single output port
// sets sustained throughput: a good request holds it for its six writes,
// rejected ones pass at one per cycle. The row stalls as a whole only when
// its last cell holds a request and the sequencer is still busy.
// A zero divisor behaves as a restoring divider does: all-ones quotient,
// the dividend as remainder. Configuration is written through cfg_valid /
// cfg_ready (always ready); indexes beyond the register list are dropped.
module block_to_chs_command_issuer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] block_number,
	input  logic        func,
	input  logic [15:0] buffer_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  reg_select,
	output logic [7:0]  reg_value,
	output logic [1:0]  error_code,
	output logic        last
);
	bchs_pkg::cfg_t  cfg_q;
	bchs_pkg::tok_t  entry;
	bchs_pkg::tok_t  cell_in  [bchs_pkg::N_CELLS];
	bchs_pkg::tok_t  cell_out [bchs_pkg::N_CELLS];
	logic            v_in     [bchs_pkg::N_CELLS];
	logic            v_out    [bchs_pkg::N_CELLS];
	logic            en;
	logic            load_ok;
	logic            load;

	// Configuration registers: always ready, unknown indexes dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_select         <= 1'b0;
			cfg_q.device_type          <= 3'd0;
			cfg_q.cylinders_total      <= 16'd0;
			cfg_q.sectors_per_track    <= 8'd63;
			cfg_q.sectors_per_cylinder <= 16'd1008;
			cfg_q.block_bytes          <= 16'd512;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bchs_pkg::CFG_DRIVE: cfg_q.drive_select         <= cfg_data[0];
				bchs_pkg::CFG_TYPE:  cfg_q.device_type          <= cfg_data[2:0];
				bchs_pkg::CFG_CYLS:  cfg_q.cylinders_total      <= cfg_data;
				bchs_pkg::CFG_SPT:   cfg_q.sectors_per_track    <= cfg_data[7:0];
				bchs_pkg::CFG_SPC:   cfg_q.sectors_per_cylinder <= cfg_data;
				bchs_pkg::CFG_BLOCK: cfg_q.block_bytes          <= cfg_data;
				default: ;
			endcase
		end
	end

	// Build the entry token; type and buffer checks are settled up front,
	// type first.
	always_comb begin
		entry        = '0;
		entry.a      = bchs_pkg::AW'(block_number);
		entry.n      = bchs_pkg::AW'(block_number);
		entry.func   = func;
		if (cfg_q.device_type != bchs_pkg::TYPE_CHS_ATA &&
		    cfg_q.device_type != bchs_pkg::TYPE_SATA) begin
			entry.err = bchs_pkg::ERR_TYPE;
		end else if (cfg_q.block_bytes > buffer_bytes) begin
			entry.err = bchs_pkg::ERR_BUF;
		end else begin
			entry.err = bchs_pkg::ERR_OK;
		end
	end

	// Advance the row unless its tail holds a request the sequencer cannot take.
	assign en       = !v_out[bchs_pkg::N_CELLS-1] || load_ok;
	assign load     = v_out[bchs_pkg::N_CELLS-1] && load_ok;
	assign in_stall = !en;

	for (genvar i = 0; i < bchs_pkg::N_CELLS; i++) begin : g_row
		logic [15:0] dvs;
		if (i == 0) begin : g_head
			assign cell_in[i] = entry;
			assign v_in[i]    = in_valid;
		end else if (i == bchs_pkg::SEC1_START) begin : g_sec1
			assign cell_in[i] = bchs_pkg::sec1_init(cell_out[i-1]);
			assign v_in[i]    = v_out[i-1];
		end else if (i == bchs_pkg::SEC2_START) begin : g_sec2
			assign cell_in[i] = bchs_pkg::sec2_init(cell_out[i-1]);
			assign v_in[i]    = v_out[i-1];
		end else begin : g_mid
			assign cell_in[i] = cell_out[i-1];
			assign v_in[i]    = v_out[i-1];
		end

		if (i >= bchs_pkg::SEC1_START && i < bchs_pkg::SEC2_START) begin : g_spc
			assign dvs = cfg_q.sectors_per_cylinder;
		end else begin : g_spt
			assign dvs = 16'(cfg_q.sectors_per_track);
		end

		bchs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (v_in[i]),
			.tok_in    (cell_in[i]),
			.divisor   (dvs),
			.valid_out (v_out[i]),
			.tok_out   (cell_out[i])
		);
	end

	bchs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.load       (load),
		.tok        (cell_out[bchs_pkg::N_CELLS-1]),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_select (reg_select),
		.reg_value  (reg_value),
		.error_code (error_code),
		.last       (last)
	);
endmodule

/* design/bchs_checker.sv */
// Port-level checks on the command issuer's result channel.
// Depends on bchs_pkg; bound to block_to_chs_command_issuer_core.
module bchs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] reg_select,
	input logic [7:0] reg_value,
	input logic [1:0] error_code,
	input logic       last
);
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'(bchs_pkg::ERR_OK) |->
			last && reg_select == 3'(bchs_pkg::SEL_DRVHEAD) && reg_value == 8'd0)
		else $error("flagged result is not a lone zero result");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == 2'(bchs_pkg::ERR_OK) |->
			last == (reg_select == 3'(bchs_pkg::SEL_COMMAND)))
		else $error("last misplaced in a run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && reg_select == $past(reg_select) + 3'd1)
		else $error("run broken off or out of order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reg_select) &&
			$stable(reg_value) && $stable(error_code) && $stable(last))
		else $error("stalled request changed");
endmodule

bind block_to_chs_command_issuer_core bchs_checker u_bchs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.reg_select (reg_select),
	.reg_value  (reg_value),
	.error_code (error_code),
	.last       (last)
);
